[hdl/inverted_crossover_with_repair_assert.svh]
// assertion macros shared by the rtl files
// expects clk and rst_n in the enclosing module
`ifndef INVERTED_CROSSOVER_WITH_REPAIR_ASSERT_SVH
`define INVERTED_CROSSOVER_WITH_REPAIR_ASSERT_SVH

// same-cycle implication
`define ICR_ASSERT_HOLD(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ICR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/icr_pkg.sv]
`timescale 1ns / 1ps

package icr_pkg;

  localparam int MAX_CITIES = 32;
  localparam int POS_W      = 5;
  localparam int GENE_W     = 5;
  localparam int CNT_W      = 6;
  localparam int MASK_W     = 1 << GENE_W;
  localparam int ADDR_W     = $clog2(MAX_CITIES);
  localparam int WORD_W     = 2 * GENE_W;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_CROSS = 1'b1;

  // normalized cut segment [lo, hi]
  typedef struct packed {
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
  } cut_t;

  // control from the sequencer to the repair unit
  typedef struct packed {
    logic clear;   // new crossover, masks restart empty
    logic scan;    // mark own-parent genes of an outside position
    logic place;   // an emitted position leaves stage one
    logic in_seg;  // that position lies in the cut segment
  } rep_ctl_t;

endpackage

[hdl/inverted_crossover_with_repair.sv]
`timescale 1ns / 1ps
// channel   | dir | handshake          | payload
// in_       | in  | in_tvalid/tready   | tuser op, tdata position..tie_coin
// out_      | out | out_tvalid/tready  | tdata position, child genes; tlast
// cfg_      | in  | cfg_wr_en          | cfg_wr_data city_count
//
// a load request writes both parent genes in one ram word
// a crossover first reads every position to scan the kept genes into the used
//   masks, then emits one result per cycle through the single ram read port,
//   via stage one and the output register; output stalls stretch the second part
// reset is synchronous, active low; the parent ram is not cleared
// a finished result waits in the output register while the next request is taken

module inverted_crossover_with_repair import icr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  // config: city_count [5:0]
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  // in_tuser: op [0]
  // in_tdata: position [4:0], gene_first [9:5], gene_second [14:10],
  //           cut_low [19:15], cut_high [24:20], tie_coin [25], zero [31:26]
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [31:0]      in_tdata,
  input  logic             in_tuser,
  // out_tdata: out_position [4:0], child_first_gene [9:5],
  //            child_second_gene [14:10], zero [15]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [15:0]      out_tdata,
  output logic             out_tlast
);

`include "inverted_crossover_with_repair_assert.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t state_r;

  // request fields
  logic [POS_W-1:0]  in_position;
  logic [GENE_W-1:0] in_gene_first, in_gene_second;
  logic [POS_W-1:0]  in_cut_low, in_cut_high;
  logic              in_tie_coin;

  logic [CNT_W-1:0]  cnt_r, cfg_clamped, cnt_m1;
  logic [POS_W-1:0]  lo_r, hi_r;
  logic [POS_W-1:0]  addr_r;
  logic [CNT_W-1:0]  seg_sum;
  logic [POS_W-1:0]  mirror;
  logic              addr_inside, addr_last;

  // stage one: ram data valid for scan or emit
  logic              scan_v_r, scan_keep_r;
  logic              emit_v_r, emit_in_r;
  logic [POS_W-1:0]  emit_pos_r;

  // output register
  logic              out_valid_r, out_last_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [GENE_W-1:0] out_first_r, out_second_r;

  logic              in_accept, start_cross, load_we;
  logic              advance, issue, ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  cut_t              cuts;
  rep_ctl_t          rep_ctl;
  logic [GENE_W-1:0] child_first, child_second;

  assign in_position    = in_tdata[4:0];
  assign in_gene_first  = in_tdata[9:5];
  assign in_gene_second = in_tdata[14:10];
  assign in_cut_low     = in_tdata[19:15];
  assign in_cut_high    = in_tdata[24:20];
  assign in_tie_coin    = in_tdata[25];

  // no new request until the last emitted position has left stage one
  assign in_tready   = (state_r == ST_IDLE) && !emit_v_r;
  assign in_accept   = in_tvalid && in_tready;
  assign start_cross = in_accept && (in_tuser == OP_CROSS);
  assign load_we     = in_accept && (in_tuser == OP_LOAD);

  // city count clamped into 2..MAX_CITIES when written
  always_comb begin
    priority if (cfg_wr_data < CNT_W'(2)) begin
      cfg_clamped = CNT_W'(2);
    end else if (cfg_wr_data > CNT_W'(MAX_CITIES)) begin
      cfg_clamped = CNT_W'(MAX_CITIES);
    end else begin
      cfg_clamped = cfg_wr_data;
    end
  end

  icr_cuts u_cuts (
    .count    (cnt_r),
    .cut_low  (in_cut_low),
    .cut_high (in_cut_high),
    .tie_coin (in_tie_coin),
    .cuts     (cuts)
  );

  // segment position lo+k reads the other parent at hi-k
  assign cnt_m1      = cnt_r - CNT_W'(1);
  assign seg_sum     = {1'b0, lo_r} + {1'b0, hi_r} - {1'b0, addr_r};
  assign mirror      = seg_sum[POS_W-1:0];
  assign addr_inside = (addr_r >= lo_r) && (addr_r <= hi_r);
  assign addr_last   = ({1'b0, addr_r} == cnt_m1);

  // stage one hands a position to the output register when it is free
  assign advance = emit_v_r && (!out_valid_r || out_tready);
  assign issue   = (state_r == ST_EMIT) && (!emit_v_r || advance);

  assign ram_re    = (state_r == ST_SCAN) || issue;
  assign ram_raddr = ((state_r == ST_EMIT) && addr_inside) ? mirror : addr_r;

  // both parents share one word: second parent in the upper half
  icr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_CITIES)
  ) u_parents (
    .clk   (clk),
    .we    (load_we),
    .waddr (in_position),
    .wdata ({in_gene_second, in_gene_first}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    rep_ctl.clear  = start_cross;
    rep_ctl.scan   = scan_v_r && scan_keep_r;
    rep_ctl.place  = advance;
    rep_ctl.in_seg = emit_in_r;
  end

  icr_repair u_repair (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (rep_ctl),
    .count             (cnt_r),
    .word              (ram_rdata),
    .child_first_gene  (child_first),
    .child_second_gene (child_second)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= CNT_W'(MAX_CITIES);
      scan_v_r    <= 1'b0;
      emit_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      addr_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        cnt_r <= cfg_clamped;
      end

      // scan data: only positions outside the segment mark used cities
      scan_v_r    <= (state_r == ST_SCAN);
      scan_keep_r <= !addr_inside;

      if (issue) begin
        emit_v_r   <= 1'b1;
        emit_pos_r <= addr_r;
        emit_in_r  <= addr_inside;
      end else if (advance) begin
        emit_v_r <= 1'b0;
      end

      if (advance) begin
        out_valid_r  <= 1'b1;
        out_pos_r    <= emit_pos_r;
        out_first_r  <= child_first;
        out_second_r <= child_second;
        out_last_r   <= ({1'b0, emit_pos_r} == cnt_m1);
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (start_cross) begin
            lo_r    <= cuts.lo;
            hi_r    <= cuts.hi;
            addr_r  <= '0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (addr_last) begin
            addr_r  <= '0;
            state_r <= ST_EMIT;
          end else begin
            addr_r <= addr_r + POS_W'(1);
          end
        end
        ST_EMIT: begin
          if (issue) begin
            if (addr_last) begin
              addr_r  <= '0;
              state_r <= ST_IDLE;
            end else begin
              addr_r <= addr_r + POS_W'(1);
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_second_r, out_first_r, out_pos_r};
  assign out_tlast  = out_last_r;

  `ICR_ASSERT_HOLD(a_idle_no_scan, state_r == ST_IDLE, !scan_v_r, "scan data while idle")
  `ICR_ASSERT_HOLD(a_stage_excl, scan_v_r, !emit_v_r, "scan and emit data overlap")
  `ICR_ASSERT_HOLD(a_out_pos_range, out_valid_r, ({1'b0, out_pos_r} < cnt_r), "result position past count")

endmodule

[hdl/icr_ram.sv]
`timescale 1ns / 1ps

module icr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/icr_cuts.sv]
`timescale 1ns / 1ps

module icr_cuts import icr_pkg::*; (
  input  logic [CNT_W-1:0] count,
  input  logic [POS_W-1:0] cut_low,
  input  logic [POS_W-1:0] cut_high,
  input  logic             tie_coin,
  output cut_t             cuts
);

  logic [CNT_W-1:0] cnt_m1;
  logic [POS_W-1:0] lo0, lo1, hi0, hi1;

  always_comb begin
    cnt_m1 = count - CNT_W'(1);
    // clamp low cut into 1..count-1
    lo0 = (cut_low == '0) ? POS_W'(1) : cut_low;
    lo1 = ({1'b0, lo0} > cnt_m1) ? cnt_m1[POS_W-1:0] : lo0;
    // clamp high cut into lo..count-1
    hi0 = (cut_high < lo1) ? lo1 : cut_high;
    hi1 = ({1'b0, hi0} > cnt_m1) ? cnt_m1[POS_W-1:0] : hi0;
    cuts.lo = lo1;
    cuts.hi = hi1;
    // pull equal cuts apart where the bounds and tie_coin allow
    if (lo1 == hi1) begin
      priority if (lo1 > POS_W'(2)) begin
        cuts.lo = lo1 - POS_W'(1);
      end else if (({1'b0, hi1} + CNT_W'(1)) < count) begin
        cuts.hi = hi1 + POS_W'(1);
      end else if (tie_coin) begin
        cuts.lo = lo1 - POS_W'(1);
      end else begin
        // raise saturates at count-1, segment stays one position wide
        cuts.hi = hi1;
      end
    end
  end

endmodule

[hdl/icr_repair.sv]
`timescale 1ns / 1ps

module icr_repair import icr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  rep_ctl_t          ctl,
  input  logic [CNT_W-1:0]  count,
  input  logic [WORD_W-1:0] word,
  output logic [GENE_W-1:0] child_first_gene,
  output logic [GENE_W-1:0] child_second_gene
);

`include "inverted_crossover_with_repair_assert.svh"

  logic [MASK_W-1:0] used_first_r, used_first_nxt;
  logic [MASK_W-1:0] used_second_r, used_second_nxt;
  logic [MASK_W-1:0] limit;
  logic [MASK_W-1:0] placed_first, placed_second;
  logic [GENE_W-1:0] gene_first, gene_second;
  logic [GENE_W-1:0] pick_first, pick_second;

  // index of the lowest set bit
  function automatic logic [GENE_W-1:0] low_index(input logic [MASK_W-1:0] v);
    logic [MASK_W-1:0] oh;
    logic [GENE_W-1:0] idx;
    oh  = v & (~v + MASK_W'(1));
    idx = '0;
    for (int j = 0; j < MASK_W; j++) begin
      if (oh[j]) begin
        idx = idx | GENE_W'(j);
      end
    end
    return idx;
  endfunction

  // take g if free, else the smallest free city, else keep g
  function automatic logic [GENE_W-1:0] pick(input logic [MASK_W-1:0] used,
                                             input logic [MASK_W-1:0] lim,
                                             input logic [GENE_W-1:0] g);
    logic [MASK_W-1:0] avail;
    avail = ~used & lim;
    if (!used[g]) begin
      return g;
    end else if (avail != '0) begin
      return low_index(avail);
    end
    return g;
  endfunction

  assign gene_first  = word[GENE_W-1:0];
  assign gene_second = word[WORD_W-1:GENE_W];

  always_comb begin
    for (int j = 0; j < MASK_W; j++) begin
      limit[j] = (CNT_W'(j) < count);
    end
    // first child draws from the second parent inside the segment
    pick_first    = pick(used_first_r, limit, gene_second);
    pick_second   = pick(used_second_r, limit, gene_first);
    placed_first  = used_first_r | (MASK_W'(1) << pick_first);
    placed_second = used_second_r | (MASK_W'(1) << pick_second);

    child_first_gene  = ctl.in_seg ? pick_first : gene_first;
    child_second_gene = ctl.in_seg ? pick_second : gene_second;

    priority if (ctl.clear) begin
      used_first_nxt  = '0;
      used_second_nxt = '0;
    end else if (ctl.scan) begin
      used_first_nxt  = used_first_r | (MASK_W'(1) << gene_first);
      used_second_nxt = used_second_r | (MASK_W'(1) << gene_second);
    end else if (ctl.place && ctl.in_seg) begin
      used_first_nxt  = placed_first;
      used_second_nxt = placed_second;
    end else begin
      used_first_nxt  = used_first_r;
      used_second_nxt = used_second_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_first_r  <= '0;
      used_second_r <= '0;
    end else begin
      used_first_r  <= used_first_nxt;
      used_second_r <= used_second_nxt;
    end
  end

  `ICR_ASSERT_NEXT(a_clear_empties, ctl.clear, (used_first_r == '0) && (used_second_r == '0), "masks not cleared on new crossover")
  `ICR_ASSERT_HOLD(a_scan_no_place, ctl.scan, !ctl.place, "scan and place together")
  `ICR_ASSERT_HOLD(a_clear_no_scan, ctl.clear, !ctl.scan, "scan during clear")

endmodule
